@@ hdl/mbe_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Mandelbrot escape-time shader package
// Shared constants, register indexes, controller states, the command and
// status bundles between controller and datapath, and the shade mapping.
// ----------------------------------------------------------------------------
package mbe_pkg;

  localparam int unsigned FRAC_BITS_DEF = 28;
  localparam int unsigned COLUMN_LIMIT  = 4096;
  localparam int unsigned ROW_LIMIT     = 4096;

  localparam int unsigned IDX_W    = 12;
  localparam int unsigned ITER_W   = 8;
  localparam int unsigned SHADE_W  = 8;
  localparam int unsigned CFG_W    = 32;
  localparam int unsigned STEP_W   = 31;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [ITER_W-1:0]  MAX_ITER     = 8'd200;
  localparam logic [SHADE_W-1:0] SHADE_INSIDE = 8'd255;

  // i/5 as (i*205) >> 10, exact for every count below the limit
  localparam logic [15:0] DIV5_MUL   = 16'd205;
  localparam int unsigned DIV5_SHIFT = 10;

  localparam logic [CFG_W-1:0]  CORNER_RE_RST = 32'hE000_0000;
  localparam logic [CFG_W-1:0]  CORNER_IM_RST = 32'h1000_0000;
  localparam logic [STEP_W-1:0] STEP_RE_RST   = 31'd1006633;
  localparam logic [STEP_W-1:0] STEP_IM_RST   = 31'd894785;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CORNER_RE = 2'd0,
    REG_CORNER_IM = 2'd1,
    REG_STEP_RE   = 2'd2,
    REG_STEP_IM   = 2'd3
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CMUL,
    ST_CADD,
    ST_ZMUL,
    ST_ZUPD
  } ctrl_state_e;

  typedef struct packed {
    logic load_in;
    logic coord_mul;
    logic coord_add;
    logic z_mul;
    logic z_upd;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic done;
  } sts_t;

  function automatic logic [SHADE_W-1:0] shade_of(input logic [ITER_W-1:0] cnt);
    logic [15:0] prod;
    prod = 16'(cnt) * DIV5_MUL;
    return cnt + SHADE_W'(prod >> DIV5_SHIFT);
  endfunction

endpackage

@@ hdl/mbe_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Mandelbrot escape-time controller
// Sequences coordinate formation and the iteration loop, owns the
// output valid flag and holds a finished pixel until the output is free.
// ----------------------------------------------------------------------------
module mbe_ctrl
  import mbe_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  output logic out_valid_o,
  input  logic out_ready_i,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  ctrl_state_e state_q, state_d;
  logic        out_valid_q, out_valid_d;
  logic        out_free;

  assign out_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load_in = 1'b1;
          state_d       = ST_CMUL;
        end
      end
      ST_CMUL: begin
        cmd_o.coord_mul = 1'b1;
        state_d         = ST_CADD;
      end
      ST_CADD: begin
        cmd_o.coord_add = 1'b1;
        state_d         = ST_ZMUL;
      end
      ST_ZMUL: begin
        cmd_o.z_mul = 1'b1;
        state_d     = ST_ZUPD;
      end
      ST_ZUPD: begin
        if (sts_i.done) begin
          // stall here until the output register frees up
          if (out_free) begin
            cmd_o.out_load = 1'b1;
            state_d        = ST_IDLE;
          end
        end else begin
          cmd_o.z_upd = 1'b1;
          state_d     = ST_ZMUL;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

@@ hdl/mbe_datapath.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Mandelbrot escape-time datapath
// Configuration registers, coordinate multiply-add with saturation, the
// shared complex square-and-add unit and the result register.
// ----------------------------------------------------------------------------
module mbe_datapath
  import mbe_pkg::*;
#(
  parameter int unsigned FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_addr_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  input  logic [IDX_W-1:0]     col_i,
  input  logic [IDX_W-1:0]     row_i,
  input  cmd_t                 cmd_i,
  output sts_t                 sts_o,
  output logic [SHADE_W-1:0]   shade_o,
  output logic [ITER_W-1:0]    iterations_o,
  output logic                 inside_o
);

  localparam int unsigned CW    = FRAC_BITS + 4;   // Q4.F coordinate
  localparam int unsigned WW    = FRAC_BITS + 6;   // Q6.F working value
  localparam int unsigned PW    = 2 * WW;          // full product
  localparam int unsigned PRE_W = IDX_W + STEP_W;  // index times step
  localparam int unsigned SW    = (CW + 1 > PRE_W + 3) ? CW + 1 : PRE_W + 3;

  localparam logic signed [SW-1:0] CMAX = {{(SW-CW+1){1'b0}}, {(CW-1){1'b1}}};
  localparam logic signed [SW-1:0] CMIN = {{(SW-CW+1){1'b1}}, {(CW-1){1'b0}}};
  localparam logic signed [PW-1:0] WMAX = {{(PW-WW+1){1'b0}}, {(WW-1){1'b1}}};
  localparam logic signed [PW-1:0] WMIN = {{(PW-WW+1){1'b1}}, {(WW-1){1'b0}}};
  localparam logic signed [WW:0]   FOUR = {4'b0000, 1'b1, {(FRAC_BITS+2){1'b0}}};

  function automatic logic signed [WW-1:0] sat_coord(input logic signed [SW-1:0] v);
    logic [CW-1:0] t;
    if (v > CMAX) begin
      t = {1'b0, {(CW-1){1'b1}}};
    end else if (v < CMIN) begin
      t = {1'b1, {(CW-1){1'b0}}};
    end else begin
      t = v[CW-1:0];
    end
    return {{2{t[CW-1]}}, t};
  endfunction

  function automatic logic signed [WW-1:0] sat_wide(input logic signed [PW-1:0] v);
    logic signed [WW-1:0] t;
    if (v > WMAX) begin
      t = WMAX[WW-1:0];
    end else if (v < WMIN) begin
      t = WMIN[WW-1:0];
    end else begin
      t = v[WW-1:0];
    end
    return t;
  endfunction

  logic [CFG_W-1:0]  corner_re_q, corner_im_q;
  logic [STEP_W-1:0] step_re_q, step_im_q;

  logic [IDX_W-1:0]  col_q, row_q;
  logic [IDX_W-1:0]  col_d, row_d;
  logic [PRE_W-1:0]  pre_re_q, pre_im_q;
  logic signed [WW-1:0] cre_q, cim_q, zre_q, zim_q;
  logic signed [WW-1:0] cre_d, cim_d;
  logic signed [PW-1:0] prr_q, pii_q, pri_q;
  logic [ITER_W-1:0]    iter_q;

  logic signed [SW-1:0]   sum_re, sum_im;
  logic signed [WW-1:0]   re2, im2, mix, nre, nim;
  logic signed [WW:0]     mag;
  logic signed [WW+1:0]   nre_sum, nim_sum;
  logic                   escape;

  logic [SHADE_W-1:0] shade_q;
  logic [ITER_W-1:0]  iter_out_q;
  logic               inside_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      corner_re_q <= CORNER_RE_RST;
      corner_im_q <= CORNER_IM_RST;
      step_re_q   <= STEP_RE_RST;
      step_im_q   <= STEP_IM_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_addr_i))
        REG_CORNER_RE: corner_re_q <= cfg_data_i;
        REG_CORNER_IM: corner_im_q <= cfg_data_i;
        REG_STEP_RE:   step_re_q   <= cfg_data_i[STEP_W-1:0];
        REG_STEP_IM:   step_im_q   <= cfg_data_i[STEP_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    col_d = (32'(col_i) >= 32'(COLUMN_LIMIT)) ? IDX_W'(COLUMN_LIMIT - 1) : col_i;
    row_d = (32'(row_i) >= 32'(ROW_LIMIT))    ? IDX_W'(ROW_LIMIT - 1)    : row_i;
  end

  always_comb begin
    sum_re = $signed({{(SW-CFG_W){corner_re_q[CFG_W-1]}}, corner_re_q})
           + $signed({{(SW-PRE_W){1'b0}}, pre_re_q});
    sum_im = $signed({{(SW-CFG_W){corner_im_q[CFG_W-1]}}, corner_im_q})
           - $signed({{(SW-PRE_W){1'b0}}, pre_im_q});
    cre_d  = sat_coord(sum_re);
    cim_d  = sat_coord(sum_im);
  end

  // floor to F fraction bits; the cross term folds in the factor of two
  always_comb begin
    re2     = sat_wide(prr_q >>> FRAC_BITS);
    im2     = sat_wide(pii_q >>> FRAC_BITS);
    mix     = sat_wide(pri_q >>> (FRAC_BITS - 1));
    mag     = {re2[WW-1], re2} + {im2[WW-1], im2};
    escape  = (mag >= FOUR);
    nre_sum = {{2{re2[WW-1]}}, re2} - {{2{im2[WW-1]}}, im2} + {{2{cre_q[WW-1]}}, cre_q};
    nim_sum = {{2{mix[WW-1]}}, mix} + {{2{cim_q[WW-1]}}, cim_q};
    nre     = sat_wide({{(PW-WW-2){nre_sum[WW+1]}}, nre_sum});
    nim     = sat_wide({{(PW-WW-2){nim_sum[WW+1]}}, nim_sum});
  end

  assign sts_o.done = escape || (iter_q == MAX_ITER - ITER_W'(1));

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      col_q <= col_d;
      row_q <= row_d;
    end
    if (cmd_i.coord_mul) begin
      pre_re_q <= PRE_W'(col_q) * PRE_W'(step_re_q);
      pre_im_q <= PRE_W'(row_q) * PRE_W'(step_im_q);
    end
    if (cmd_i.coord_add) begin
      cre_q  <= cre_d;
      cim_q  <= cim_d;
      zre_q  <= cre_d;
      zim_q  <= cim_d;
      iter_q <= '0;
    end
    if (cmd_i.z_mul) begin
      prr_q <= PW'(zre_q) * PW'(zre_q);
      pii_q <= PW'(zim_q) * PW'(zim_q);
      pri_q <= PW'(zre_q) * PW'(zim_q);
    end
    if (cmd_i.z_upd) begin
      zre_q  <= nre;
      zim_q  <= nim;
      iter_q <= iter_q + ITER_W'(1);
    end
    if (cmd_i.out_load) begin
      if (escape) begin
        shade_q    <= shade_of(iter_q);
        iter_out_q <= iter_q;
        inside_q   <= 1'b0;
      end else begin
        shade_q    <= SHADE_INSIDE;
        iter_out_q <= MAX_ITER;
        inside_q   <= 1'b1;
      end
    end
  end

  assign shade_o      = shade_q;
  assign iterations_o = iter_out_q;
  assign inside_o     = inside_q;

endmodule

@@ hdl/mandelbrot_escape_time_shader.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Mandelbrot escape-time shader
// Maps one pixel index pair to an escape-time grey shade.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream carries col and row; output stream carries shade and
//   iteration count in tdata and the inside flag in tuser.
//   The plain write port loads corner_re, corner_im, step_re, step_im;
//   write only while no pixel is in flight.
//   Sequence: the pixel is taken, c is formed by a multiply and then an add,
//   then each escape test uses the shared complex multiply unit (three
//   products in one state, floor/saturate/add/escape test in the next) until
//   an escape or the iteration limit; tvalid rises the cycle after the
//   result is loaded. One pixel is processed at a time.
//   The result sits in an output register; the next pixel is taken while
//   it waits. If the receiver stalls, a finished pixel waits in the
//   iteration unit and no further input is taken.
//   Reset: registers return to their default view, streams go empty.
// ----------------------------------------------------------------------------
module mandelbrot_escape_time_shader
  import mbe_pkg::*;
#(
  parameter int unsigned FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_addr_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [23:0]          s_axis_tdata,   // col[11:0], row[23:12]
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [15:0]          m_axis_tdata,   // shade[7:0], iterations[15:8]
  output logic [0:0]           m_axis_tuser    // inside_res[0]
);

  cmd_t               cmd;
  sts_t               sts;
  logic [SHADE_W-1:0] shade;
  logic [ITER_W-1:0]  iterations;
  logic               inside_res;

  mbe_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  mbe_datapath #(
    .FRAC_BITS (FRAC_BITS)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_addr_i   (cfg_addr_i),
    .cfg_data_i   (cfg_data_i),
    .col_i        (s_axis_tdata[11:0]),
    .row_i        (s_axis_tdata[23:12]),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .shade_o      (shade),
    .iterations_o (iterations),
    .inside_o     (inside_res)
  );

  assign m_axis_tdata = {iterations, shade};
  assign m_axis_tuser = inside_res;

endmodule

@@ hdl/mbe_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Mandelbrot escape-time port checker
// Port-level properties of the shader, bound to the top level.
// ----------------------------------------------------------------------------
module mbe_checker
  import mbe_pkg::*;
(
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 s_axis_tvalid,
  input logic                 s_axis_tready,
  input logic                 m_axis_tvalid,
  input logic                 m_axis_tready,
  input logic [15:0]          m_axis_tdata,
  input logic [0:0]           m_axis_tuser
);

  // one pixel at a time: no back-to-back input transfers
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("input taken while a pixel is in flight");

  a_inside_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser[0]) |->
      (m_axis_tdata[7:0] == SHADE_INSIDE && m_axis_tdata[15:8] == MAX_ITER))
    else $error("inside pixel with wrong shade or count");

  a_escape_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tuser[0]) |->
      (m_axis_tdata[15:8] < MAX_ITER &&
       m_axis_tdata[7:0] == shade_of(m_axis_tdata[15:8])))
    else $error("escaped pixel with inconsistent shade or count");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=>
      (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)))
    else $error("stalled result changed");

endmodule

bind mandelbrot_escape_time_shader mbe_checker u_mbe_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

@@ tb/mandelbrot_escape_time_shader_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Mandelbrot escape-time shader testbench
// Streams pixel coordinates through the shader under a series of view
// windows and checks every shade, iteration count and inside flag. The
// expected values come from a fixed-point escape-time predictor inside the
// testbench. The input side sends in random bursts and the output side
// stalls at random.
// ----------------------------------------------------------------------------
module mandelbrot_escape_time_shader_test;
  import mbe_pkg::*;

  localparam longint WIDE_MAX   = (longint'(1) << (FRAC_BITS_DEF + 5)) - 1;
  localparam longint WIDE_MIN   = -(longint'(1) << (FRAC_BITS_DEF + 5));
  localparam longint COORD_MAX  = (longint'(1) << (FRAC_BITS_DEF + 3)) - 1;
  localparam longint COORD_MIN  = -(longint'(1) << (FRAC_BITS_DEF + 3));
  localparam longint ESC_LIMIT  = longint'(4) << FRAC_BITS_DEF;
  localparam int     TAIL_WAIT  = 450;

  typedef struct packed {
    logic [SHADE_W-1:0] shade;
    logic [ITER_W-1:0]  iters;
    logic               in_set;
  } pixel_res_t;

  class shade_book;
    pixel_res_t  pending[$];
    longint      corner_re;
    longint      corner_im;
    longint      step_re;
    longint      step_im;
    int unsigned errors;

    function new();
      corner_re = longint'($signed(CORNER_RE_RST));
      corner_im = longint'($signed(CORNER_IM_RST));
      step_re   = longint'(STEP_RE_RST);
      step_im   = longint'(STEP_IM_RST);
      errors    = 0;
    endfunction

    function void set_reg(cfg_idx_e idx, logic [CFG_W-1:0] data);
      case (idx)
        REG_CORNER_RE: corner_re = longint'($signed(data));
        REG_CORNER_IM: corner_im = longint'($signed(data));
        REG_STEP_RE:   step_re   = longint'(data[STEP_W-1:0]);
        REG_STEP_IM:   step_im   = longint'(data[STEP_W-1:0]);
        default: ;
      endcase
    endfunction

    function longint clip(longint v, longint lo, longint hi);
      return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    // floor(a*b / 2^F), saturated to the wide format
    function longint fmul(longint a, longint b);
      logic signed [127:0] wa;
      logic signed [127:0] wb;
      logic signed [127:0] prod;
      wa = a;
      wb = b;
      prod = (wa * wb) >>> FRAC_BITS_DEF;
      if (prod > WIDE_MAX) return WIDE_MAX;
      if (prod < WIDE_MIN) return WIDE_MIN;
      return longint'(prod);
    endfunction

    function pixel_res_t shade_for(logic [IDX_W-1:0] col, logic [IDX_W-1:0] row);
      longint      c_re;
      longint      c_im;
      longint      z_re;
      longint      z_im;
      longint      re2;
      longint      im2;
      longint      nxt_re;
      int unsigned n;
      pixel_res_t  res;
      c_re = clip(corner_re + longint'(col) * step_re, COORD_MIN, COORD_MAX);
      c_im = clip(corner_im - longint'(row) * step_im, COORD_MIN, COORD_MAX);
      z_re = c_re;
      z_im = c_im;
      n = 0;
      while (n < MAX_ITER) begin
        re2 = fmul(z_re, z_re);
        im2 = fmul(z_im, z_im);
        if (re2 + im2 >= ESC_LIMIT) break;
        nxt_re = clip(re2 - im2 + c_re, WIDE_MIN, WIDE_MAX);
        z_im   = clip(fmul(2 * z_re, z_im) + c_im, WIDE_MIN, WIDE_MAX);
        z_re   = nxt_re;
        n++;
      end
      if (n == MAX_ITER) begin
        res = '{SHADE_INSIDE, MAX_ITER, 1'b1};
      end else begin
        res = '{SHADE_W'(n + n / 5), ITER_W'(n), 1'b0};
      end
      return res;
    endfunction

    function void note_pixel(logic [IDX_W-1:0] col, logic [IDX_W-1:0] row);
      pending.push_back(shade_for(col, row));
    endfunction

    function void report(string what);
      errors++;
      if (errors <= 10) $display("%0t ns: %s", $time, what);
    endfunction

    function void check_result(pixel_res_t got);
      pixel_res_t want;
      if (pending.size() == 0) begin
        report($sformatf("result with nothing pending: shade %0d iters %0d in_set %0d",
                         got.shade, got.iters, got.in_set));
        return;
      end
      want = pending.pop_front();
      if (got.shade !== want.shade || got.iters !== want.iters ||
          got.in_set !== want.in_set) begin
        report($sformatf("mismatch: shade %0d/%0d iters %0d/%0d in_set %0d/%0d (exp/act)",
                         want.shade, got.shade, want.iters, got.iters,
                         want.in_set, got.in_set));
      end
    endfunction
  endclass

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_addr_i = '0;
  logic [CFG_W-1:0]     cfg_data_i = '0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [23:0]          s_axis_tdata = '0;   // col[11:0], row[23:12]
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [15:0]          m_axis_tdata;        // shade[7:0], iterations[15:8]
  logic [0:0]           m_axis_tuser;        // inside_res[0]

  shade_book   book = new();
  int unsigned burst_left = 0;

  mandelbrot_escape_time_shader u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always #10 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      book.check_result('{m_axis_tdata[7:0], m_axis_tdata[15:8], m_axis_tuser[0]});
    end
  end

  // receiver: segments of always-ready, random, mostly-ready and hard stall
  initial begin
    int unsigned pick;
    int unsigned len;
    @(posedge rst_ni);
    forever begin
      pick = $urandom_range(0, 3);
      len  = (pick == 3) ? $urandom_range(1, 12) : $urandom_range(1, 40);
      repeat (len) begin
        @(posedge clk_i);
        case (pick)
          0: m_axis_tready <= 1'b1;
          1: m_axis_tready <= 1'($urandom_range(0, 1));
          2: m_axis_tready <= ($urandom_range(0, 7) != 0);
          default: m_axis_tready <= 1'b0;
        endcase
      end
    end
  end

  task automatic load_window(input logic [CFG_W-1:0] c_re, input logic [CFG_W-1:0] c_im,
                             input logic [CFG_W-1:0] s_re, input logic [CFG_W-1:0] s_im);
    logic [CFG_W-1:0] vals [4];
    vals = '{c_re, c_im, s_re, s_im};
    for (int k = 0; k < 4; k++) begin
      cfg_we_i   <= 1'b1;
      cfg_addr_i <= cfg_idx_e'(k);
      cfg_data_i <= vals[k];
      @(posedge clk_i);
      book.set_reg(cfg_idx_e'(k), vals[k]);
    end
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic send_pixel(input logic [IDX_W-1:0] col, input logic [IDX_W-1:0] row);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {row, col};
    do @(posedge clk_i); while (!s_axis_tready);
    book.note_pixel(col, row);
    if (burst_left == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk_i);
      burst_left = ($urandom_range(0, 3) == 0) ? 40 : $urandom_range(0, 8);
    end else begin
      burst_left--;
    end
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (book.pending.size() != 0);
  endtask

  initial begin
    logic [IDX_W-1:0] col;
    logic [IDX_W-1:0] row;
    logic [CFG_W-1:0] w_re;
    logic [CFG_W-1:0] w_im;
    logic [CFG_W-1:0] w_sre;
    logic [CFG_W-1:0] w_sim;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // default view, index extremes and alternating bit patterns
    send_pixel(12'd0, 12'd0);
    send_pixel(12'd4095, 12'd4095);
    send_pixel(12'd0, 12'd4095);
    send_pixel(12'd4095, 12'd0);
    send_pixel(12'hAAA, 12'h555);
    send_pixel(12'h555, 12'hAAA);
    send_pixel(12'd533, 12'd300);
    drain();

    // c = 0: never escapes
    load_window(32'h0, 32'h0, 32'h0, 32'h0);
    send_pixel(12'd17, 12'd42);
    drain();

    // coordinates saturate, point already outside; step bit 31 is dropped
    load_window(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
    send_pixel(12'd0, 12'd0);
    send_pixel(12'd4095, 12'd4095);
    send_pixel(12'd1, 12'd1);
    drain();

    load_window(32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h0);
    send_pixel(12'd0, 12'd9);
    send_pixel(12'd4095, 12'd4095);
    drain();

    // real axis from -2 in quarter steps: boundary at -2 and 0.25
    load_window(32'hE000_0000, 32'h0, 32'h0400_0000, 32'h0400_0000);
    send_pixel(12'd0, 12'd0);
    send_pixel(12'd1, 12'd0);
    send_pixel(12'd6, 12'd0);
    send_pixel(12'd9, 12'd0);
    send_pixel(12'd10, 12'd0);
    send_pixel(12'd1, 12'd4);
    drain();

    // c = i: periodic orbit through the doubled cross term
    load_window(32'h0, 32'h1000_0000, 32'h0400_0000, 32'h0400_0000);
    send_pixel(12'd0, 12'd0);
    send_pixel(12'd2, 12'd4);
    drain();

    col = '0;
    row = '0;
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin
          w_re  = CORNER_RE_RST;
          w_im  = CORNER_IM_RST;
          w_sre = CFG_W'(STEP_RE_RST);
          w_sim = CFG_W'(STEP_IM_RST);
        end
        3: begin
          // deep zoom near the set boundary
          w_re  = $urandom_range(0, 3 << 27) - (3 << 28);
          w_im  = $urandom_range(0, 1 << 28);
          w_sre = $urandom_range(1, 1024);
          w_sim = $urandom_range(1, 1024);
        end
        5: begin
          w_re  = $urandom;
          w_im  = $urandom;
          w_sre = $urandom;
          w_sim = $urandom;
        end
        default: begin
          w_re  = $urandom_range(0, 3 << 28) - (5 << 27);
          w_im  = $urandom_range(0, 3 << 27);
          w_sre = $urandom_range(1, 1 << 17) | (CFG_W'($urandom_range(0, 1)) << 31);
          w_sim = $urandom_range(1, 1 << 17);
        end
      endcase
      load_window(w_re, w_im, w_sre, w_sim);
      for (int n = 0; n < 180; n++) begin
        if (ph == 2 && n == 90) drain();
        if ($urandom_range(0, 3) == 0) begin
          col = col + 1'b1;
        end else begin
          col = IDX_W'($urandom_range(0, 4095));
          row = IDX_W'($urandom_range(0, 4095));
        end
        send_pixel(col, row);
      end
      drain();
    end

    repeat (TAIL_WAIT) @(posedge clk_i);
    if (book.errors == 0 && book.pending.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #40_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule
